FILE: src/ute_pkg.sv
// Shared types, constants and month table for the Unix time to calendar date converter.
package ute_pkg;

    localparam int SECS_PER_HOUR  = 3600;
    localparam int SECS_PER_MIN   = 60;
    localparam int DAY_DIV_SHIFT  = 7;
    localparam int DAY_DIV_ODD    = 675;
    localparam int DAY_RECIP      = 101806632;
    localparam int DAYS_PER_CYCLE = 1461;
    localparam int CYCLE_RECIP    = 2939744;
    localparam int HOUR_RECIP     = 4660;
    localparam int MIN_RECIP      = 1092;
    localparam int YEAR_BASE      = 1970;
    localparam int YEAR1_START    = 365;
    localparam int YEAR2_START    = 730;
    localparam int YEAR3_START    = 1096;
    localparam int ZONE_RESET     = 8;

    localparam int ADDR_W = 3;
    localparam logic REG_ZONE = 1'b0;

    typedef struct packed {
        logic [15:0] days;
        logic [16:0] secs;
    } split_t;

    typedef struct packed {
        logic [5:0]  cycles;
        logic [10:0] day_of_cycle;
        logic [4:0]  hour;
        logic [11:0] sec_of_hour;
    } cycle_t;

    typedef struct packed {
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day_of_month;
        logic [3:0]  month;
        logic [11:0] year;
    } date_t;

    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
        logic [8:0] base;
        case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && idx >= 4'd2)
        begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

FILE: src/ute_split.sv
// Zone offset add and split of local seconds into days and seconds of day.
module ute_split
    import ute_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [3:0]  zone,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] epoch,
    output logic        out_valid,
    input  logic        out_ready,
    output split_t      out_split
);

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic        load1, load2, load3, load4;

    logic [32:0] local1_reg, local1_next;
    logic [32:0] local2_reg;
    logic [52:0] prod2_reg, prod2_next;
    logic [15:0] q3_reg, q3_next;
    logic [10:0] r3_reg, r3_next;
    logic [6:0]  low3_reg;
    split_t      split4_reg, split4_next;

    logic [25:0] r_wide;
    logic [10:0] r_fix;

    assign load4    = !v4_reg || out_ready;
    assign load3    = !v3_reg || load4;
    assign load2    = !v2_reg || load3;
    assign load1    = !v1_reg || load2;
    assign in_ready = load1;

    always_comb
    begin
        local1_next = {1'b0, epoch} + 33'(zone) * 33'(SECS_PER_HOUR);
        prod2_next  = 53'(local1_reg[32:DAY_DIV_SHIFT]) * 53'(DAY_RECIP);
        q3_next     = prod2_reg[51:36];
        r_wide      = local2_reg[32:DAY_DIV_SHIFT] - 26'(q3_next) * 26'(DAY_DIV_ODD);
        r3_next     = r_wide[10:0];
        r_fix       = r3_reg;
        split4_next.days = q3_reg;
        if (r3_reg >= 11'(DAY_DIV_ODD))
        begin
            split4_next.days = q3_reg + 16'd1;
            r_fix            = r3_reg - 11'(DAY_DIV_ODD);
        end
        split4_next.secs = {r_fix[9:0], low3_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (load1) v1_reg <= in_valid;
            if (load2) v2_reg <= v1_reg;
            if (load3) v3_reg <= v2_reg;
            if (load4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load1 && in_valid)
        begin
            local1_reg <= local1_next;
        end
        if (load2 && v1_reg)
        begin
            prod2_reg  <= prod2_next;
            local2_reg <= local1_reg;
        end
        if (load3 && v2_reg)
        begin
            q3_reg   <= q3_next;
            r3_reg   <= r3_next;
            low3_reg <= local2_reg[DAY_DIV_SHIFT-1:0];
        end
        if (load4 && v3_reg)
        begin
            split4_reg <= split4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_split = split4_reg;

`ifndef ASSERT_OFF
    a_secs_range: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> (split4_reg.secs < 17'd86400))
        else $error("seconds of day out of range");
`endif

endmodule

FILE: src/ute_cycle.sv
// Split of days into four-year cycles and of seconds of day into hours.
module ute_cycle
    import ute_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  split_t in_split,
    output logic   out_valid,
    input  logic   out_ready,
    output cycle_t out_cycle
);

    logic        v5_reg, v6_reg, v7_reg;
    logic        load5, load6, load7;

    logic [37:0] prodc5_reg, prodc5_next;
    logic [29:0] prodh5_reg, prodh5_next;
    split_t      split5_reg;
    logic [5:0]  cyc6_reg, cyc6_next;
    logic [11:0] dr6_reg, dr6_next;
    logic [4:0]  hr6_reg, hr6_next;
    logic [12:0] sr6_reg, sr6_next;
    cycle_t      cycle7_reg, cycle7_next;

    logic [15:0] dr_wide;
    logic [16:0] sr_wide;
    logic [11:0] dr_fix;
    logic [12:0] sr_fix;

    assign load7    = !v7_reg || out_ready;
    assign load6    = !v6_reg || load7;
    assign load5    = !v5_reg || load6;
    assign in_ready = load5;

    always_comb
    begin
        prodc5_next = 38'(in_split.days) * 38'(CYCLE_RECIP);
        prodh5_next = 30'(in_split.secs) * 30'(HOUR_RECIP);
        cyc6_next   = prodc5_reg[37:32];
        hr6_next    = prodh5_reg[28:24];
        dr_wide     = split5_reg.days - 16'(cyc6_next) * 16'(DAYS_PER_CYCLE);
        sr_wide     = split5_reg.secs - 17'(hr6_next) * 17'(SECS_PER_HOUR);
        dr6_next    = dr_wide[11:0];
        sr6_next    = sr_wide[12:0];

        dr_fix             = dr6_reg;
        cycle7_next.cycles = cyc6_reg;
        if (dr6_reg >= 12'(DAYS_PER_CYCLE))
        begin
            dr_fix             = dr6_reg - 12'(DAYS_PER_CYCLE);
            cycle7_next.cycles = cyc6_reg + 6'd1;
        end
        sr_fix           = sr6_reg;
        cycle7_next.hour = hr6_reg;
        if (sr6_reg >= 13'(SECS_PER_HOUR))
        begin
            sr_fix           = sr6_reg - 13'(SECS_PER_HOUR);
            cycle7_next.hour = hr6_reg + 5'd1;
        end
        cycle7_next.day_of_cycle = dr_fix[10:0];
        cycle7_next.sec_of_hour  = sr_fix[11:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (load5) v5_reg <= in_valid;
            if (load6) v6_reg <= v5_reg;
            if (load7) v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load5 && in_valid)
        begin
            prodc5_reg <= prodc5_next;
            prodh5_reg <= prodh5_next;
            split5_reg <= in_split;
        end
        if (load6 && v5_reg)
        begin
            cyc6_reg <= cyc6_next;
            dr6_reg  <= dr6_next;
            hr6_reg  <= hr6_next;
            sr6_reg  <= sr6_next;
        end
        if (load7 && v6_reg)
        begin
            cycle7_reg <= cycle7_next;
        end
    end

    assign out_valid = v7_reg;
    assign out_cycle = cycle7_reg;

endmodule

FILE: src/ute_date.sv
// Year, month and day lookup within a four-year cycle, minute split, output register.
module ute_date
    import ute_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  cycle_t in_cycle,
    output logic   out_valid,
    input  logic   out_ready,
    output date_t  out_date
);

    logic        v8_reg, v9_reg;
    logic        load8, load9;

    logic [11:0] year8_reg, year8_next;
    logic        leap8_reg, leap8_next;
    logic [8:0]  doy8_reg, doy8_next;
    logic [4:0]  hour8_reg;
    logic [11:0] sh8_reg;
    logic [22:0] prodm8_reg, prodm8_next;
    date_t       date9_reg, date9_next;

    logic [1:0]  yoff;
    logic [10:0] dc;
    logic [3:0]  midx;
    logic [8:0]  dom_wide;
    logic [5:0]  min_est;
    logic [11:0] t_wide;

    assign load9    = !v9_reg || out_ready;
    assign load8    = !v8_reg || load9;
    assign in_ready = load8;

    always_comb
    begin
        dc         = in_cycle.day_of_cycle;
        leap8_next = 1'b0;
        if (dc < 11'(YEAR1_START))
        begin
            yoff      = 2'd0;
            doy8_next = dc[8:0];
        end
        else if (dc < 11'(YEAR2_START))
        begin
            yoff      = 2'd1;
            doy8_next = 9'(dc - 11'(YEAR1_START));
        end
        else if (dc < 11'(YEAR3_START))
        begin
            yoff       = 2'd2;
            leap8_next = 1'b1;
            doy8_next  = 9'(dc - 11'(YEAR2_START));
        end
        else
        begin
            yoff      = 2'd3;
            doy8_next = 9'(dc - 11'(YEAR3_START));
        end
        year8_next  = 12'(YEAR_BASE) + {4'd0, in_cycle.cycles, 2'b00} + 12'(yoff);
        prodm8_next = 23'(in_cycle.sec_of_hour) * 23'(MIN_RECIP);

        midx = 4'd0;
        for (int k = 1; k < 12; k++)
        begin
            if (doy8_reg >= month_start(leap8_reg, 4'(k)))
            begin
                midx = 4'(k);
            end
        end
        dom_wide = doy8_reg - month_start(leap8_reg, midx) + 9'd1;

        min_est = prodm8_reg[21:16];
        t_wide  = sh8_reg - 12'(min_est) * 12'(SECS_PER_MIN);
        if (t_wide >= 12'(SECS_PER_MIN))
        begin
            min_est = min_est + 6'd1;
        end

        date9_next.year         = year8_reg;
        date9_next.month        = midx + 4'd1;
        date9_next.day_of_month = dom_wide[4:0];
        date9_next.hour         = hour8_reg;
        date9_next.minute       = min_est;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end
        else
        begin
            if (load8) v8_reg <= in_valid;
            if (load9) v9_reg <= v8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load8 && in_valid)
        begin
            year8_reg  <= year8_next;
            leap8_reg  <= leap8_next;
            doy8_reg   <= doy8_next;
            hour8_reg  <= in_cycle.hour;
            sh8_reg    <= in_cycle.sec_of_hour;
            prodm8_reg <= prodm8_next;
        end
        if (load9 && v8_reg)
        begin
            date9_reg <= date9_next;
        end
    end

    assign out_valid = v9_reg;
    assign out_date  = date9_reg;

`ifndef ASSERT_OFF
    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        v9_reg |-> (date9_reg.month >= 4'd1 && date9_reg.month <= 4'd12))
        else $error("month out of range");
    a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
        v9_reg |-> (date9_reg.day_of_month >= 5'd1))
        else $error("day of month is zero");
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        v9_reg |-> (date9_reg.hour <= 5'd23 && date9_reg.minute <= 6'd59))
        else $error("hour or minute out of range");
`endif

endmodule

FILE: src/unix_time_to_calendar_date.sv
// Top level: Unix seconds to local calendar date, stream ports and register port.
//
//  channel  | direction | word
//  s_*      | in        | epoch_seconds[31:0]
//  m_*      | out       | year, month, day_of_month, hour, minute
//  apb      | in/out    | zone_offset_hours at byte address 0
//
// Nine register stages from s_tdata to m_tdata, one word per cycle while m_tready is high.
// Divisions use pipelined reciprocal multipliers, and each stage holds one word.
// Reset clears all stage valid bits and sets the zone offset to 8 hours.
// A stall on m_tready holds the output word; earlier stages still fill any bubbles.
module unix_time_to_calendar_date
    import ute_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // [31:0] epoch_seconds
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // year[11:0], month, day_of_month, hour, minute
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [3:0] zone_reg, zone_next;
    logic       cfg_write;

    logic       split_valid, split_ready;
    split_t     split_word;
    logic       cycle_valid, cycle_ready;
    cycle_t     cycle_word;
    date_t      date_word;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_ZONE);
    assign zone_next = cfg_write ? pwdata[3:0] : zone_reg;
    assign prdata    = (paddr[ADDR_W-1] == REG_ZONE) ? {28'd0, zone_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg <= 4'(ZONE_RESET);
        end
        else
        begin
            zone_reg <= zone_next;
        end
    end

    ute_split u_split
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .zone      (zone_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .epoch     (s_tdata),
        .out_valid (split_valid),
        .out_ready (split_ready),
        .out_split (split_word)
    );

    ute_cycle u_cycle
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (split_valid),
        .in_ready  (split_ready),
        .in_split  (split_word),
        .out_valid (cycle_valid),
        .out_ready (cycle_ready),
        .out_cycle (cycle_word)
    );

    ute_date u_date
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cycle_valid),
        .in_ready  (cycle_ready),
        .in_cycle  (cycle_word),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_date  (date_word)
    );

    assign m_tdata = date_word;

endmodule
